[rtl/core/rc2c_pkg.sv]
// ----------------------------------------------------------------------------
// rc2c_pkg
// Shared types, constants and tables for the RC2 CBC cipher block.
// ----------------------------------------------------------------------------
package rc2c_pkg;

	// operation codes
	localparam logic [1:0] OP_ENC_KEY = 2'd0;
	localparam logic [1:0] OP_DEC_KEY = 2'd1;
	localparam logic [1:0] OP_ENC_BLK = 2'd2;
	localparam logic [1:0] OP_DEC_BLK = 2'd3;

	localparam int KEY_BYTES = 128;
	localparam int KEY_WORDS = KEY_BYTES / 2;
	localparam int KB_AW = $clog2(KEY_BYTES);
	localparam int KW_AW = $clog2(KEY_WORDS);

	localparam logic [63:0] CHAIN_RESET = 64'hEFCD_AB89_6745_2301;
	localparam logic [63:0] PAD_FULL    = 64'h0808_0808_0808_0808;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXT_RD,
		ST_EXT_WR,
		ST_PACK_LO,
		ST_PACK_HI,
		ST_PACK_WR,
		ST_RUN,
		ST_DONE
	} state_t;

	// control of one cipher step
	typedef struct packed {
		logic       dec;
		logic       mash;
		logic [1:0] w;
	} step_ctl_t;

	// key expansion permutation
	localparam logic [7:0] PI_TABLE [256] = '{
		8'hD9,8'h78,8'hF9,8'hC4,8'h19,8'hDD,8'hB5,8'hED,8'h28,8'hE9,8'hFD,8'h79,8'h4A,8'hA0,8'hD8,8'h9D,
		8'hC6,8'h7E,8'h37,8'h83,8'h2B,8'h76,8'h53,8'h8E,8'h62,8'h4C,8'h64,8'h88,8'h44,8'h8B,8'hFB,8'hA2,
		8'h17,8'h9A,8'h59,8'hF5,8'h87,8'hB3,8'h4F,8'h13,8'h61,8'h45,8'h6D,8'h8D,8'h09,8'h81,8'h7D,8'h32,
		8'hBD,8'h8F,8'h40,8'hEB,8'h86,8'hB7,8'h7B,8'h0B,8'hF0,8'h95,8'h21,8'h22,8'h5C,8'h6B,8'h4E,8'h82,
		8'h54,8'hD6,8'h65,8'h93,8'hCE,8'h60,8'hB2,8'h1C,8'h73,8'h56,8'hC0,8'h14,8'hA7,8'h8C,8'hF1,8'hDC,
		8'h12,8'h75,8'hCA,8'h1F,8'h3B,8'hBE,8'hE4,8'hD1,8'h42,8'h3D,8'hD4,8'h30,8'hA3,8'h3C,8'hB6,8'h26,
		8'h6F,8'hBF,8'h0E,8'hDA,8'h46,8'h69,8'h07,8'h57,8'h27,8'hF2,8'h1D,8'h9B,8'hBC,8'h94,8'h43,8'h03,
		8'hF8,8'h11,8'hC7,8'hF6,8'h90,8'hEF,8'h3E,8'hE7,8'h06,8'hC3,8'hD5,8'h2F,8'hC8,8'h66,8'h1E,8'hD7,
		8'h08,8'hE8,8'hEA,8'hDE,8'h80,8'h52,8'hEE,8'hF7,8'h84,8'hAA,8'h72,8'hAC,8'h35,8'h4D,8'h6A,8'h2A,
		8'h96,8'h1A,8'hD2,8'h71,8'h5A,8'h15,8'h49,8'h74,8'h4B,8'h9F,8'hD0,8'h5E,8'h04,8'h18,8'hA4,8'hEC,
		8'hC2,8'hE0,8'h41,8'h6E,8'h0F,8'h51,8'hCB,8'hCC,8'h24,8'h91,8'hAF,8'h50,8'hA1,8'hF4,8'h70,8'h39,
		8'h99,8'h7C,8'h3A,8'h85,8'h23,8'hB8,8'hB4,8'h7A,8'hFC,8'h02,8'h36,8'h5B,8'h25,8'h55,8'h97,8'h31,
		8'h2D,8'h5D,8'hFA,8'h98,8'hE3,8'h8A,8'h92,8'hAE,8'h05,8'hDF,8'h29,8'h10,8'h67,8'h6C,8'hBA,8'hC9,
		8'hD3,8'h00,8'hE6,8'hCF,8'hE1,8'h9E,8'hA8,8'h2C,8'h63,8'h16,8'h01,8'h3F,8'h58,8'hE2,8'h89,8'hA9,
		8'h0D,8'h38,8'h34,8'h1B,8'hAB,8'h33,8'hFF,8'hB0,8'hBB,8'h48,8'h0C,8'h5F,8'hB9,8'hB1,8'hCD,8'h2E,
		8'hC5,8'hF3,8'hDB,8'h47,8'hE5,8'hA5,8'h9C,8'h77,8'h0A,8'hA6,8'h20,8'h68,8'hFE,8'h7F,8'hC1,8'hAD
	};

	// left rotate of a word by the amount of its lane (1, 2, 3, 5)
	function automatic logic [15:0] rotl_lane(input logic [15:0] v, input logic [1:0] w);
		logic [15:0] r;
		unique case (w)
			2'd0: r = {v[14:0], v[15]};
			2'd1: r = {v[13:0], v[15:14]};
			2'd2: r = {v[12:0], v[15:13]};
			default: r = {v[10:0], v[15:11]};
		endcase
		return r;
	endfunction

	// right rotate, the inverse of rotl_lane
	function automatic logic [15:0] rotr_lane(input logic [15:0] v, input logic [1:0] w);
		logic [15:0] r;
		unique case (w)
			2'd0: r = {v[0], v[15:1]};
			2'd1: r = {v[1:0], v[15:2]};
			2'd2: r = {v[2:0], v[15:3]};
			default: r = {v[4:0], v[15:5]};
		endcase
		return r;
	endfunction

endpackage

[rtl/core/rc2c_step.sv]
// ----------------------------------------------------------------------------
// rc2c_step
// One mix or mash step of RC2 on a single 16-bit lane, either direction.
// ----------------------------------------------------------------------------
module rc2c_step import rc2c_pkg::*; (
	input  logic [63:0] r,
	input  step_ctl_t   ctl,
	input  logic [15:0] k,
	output logic [63:0] r_next
);

	logic [15:0] rw [4];
	logic [15:0] cur, p1, p2, p3, f, res;

	// split into lanes and pick neighbors
	always_comb begin
		for (int n = 0; n < 4; n++) begin
			rw[n] = r[16*n +: 16];
		end
		cur = rw[ctl.w];
		p1  = rw[ctl.w + 2'd3];
		p2  = rw[ctl.w + 2'd2];
		p3  = rw[ctl.w + 2'd1];
		f   = (p3 & ~p1) + (p2 & p1);
	end

	// lane update
	always_comb begin
		if (!ctl.dec) begin
			if (ctl.mash) res = cur + k;
			else res = rotl_lane(cur + f + k, ctl.w);
		end else begin
			if (ctl.mash) res = cur - k;
			else res = rotr_lane(cur, ctl.w) - (f + k);
		end
	end

	// write back the updated lane
	always_comb begin
		r_next = r;
		r_next[16*ctl.w +: 16] = res;
	end

endmodule

[rtl/core/rc2_cbc_cipher.sv]
// ----------------------------------------------------------------------------
// rc2_cbc_cipher
// RC2 in CBC mode with separate encrypt and decrypt key stores, padding and
// pad removal.
// ----------------------------------------------------------------------------
// block item: accepted in idle, then one mix or mash step per key word read from
//   the key word memory, then a result state; a full final encrypt block runs again
// key item: accepted in idle; the last key byte fills the rest of the 128-byte
//   buffer, a read and a write per filled byte, then packs the 64 key words
// reset clears the sequencer, key byte count, output valid and both chains;
//   key memories hold nothing valid until a key is loaded
module rc2_cbc_cipher import rc2c_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        ready,
	input  logic [1:0]  operation,
	input  logic [7:0]  key_byte,
	input  logic [63:0] block_data,
	input  logic [3:0]  byte_count,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] out_block,
	output logic [3:0]  out_bytes,
	output logic        out_last,
	output logic        pad_error
);

	state_t state_q, state_d;

	logic [7:0]       cnt_q;
	logic             kdec_q;
	logic [KB_AW-1:0] ext_i_q, ext_n_q;
	logic [7:0]       prev_q, lo_q;
	logic [KW_AW-1:0] pj_q;
	logic [63:0]      r_q, cin_q, enc_chain_q, dec_chain_q;
	logic             dec_q, mash_q, last_q, pad_pend_q;
	logic [3:0]       rnd_q;
	logic [1:0]       w_q;
	logic             out_valid_q;
	logic [63:0]      out_block_q;
	logic [3:0]       out_bytes_q;
	logic             out_last_q, pad_error_q;

	// key byte buffer and key word memories
	logic [7:0]       kb_mem [KEY_BYTES];
	logic [7:0]       kb_rd_q;
	logic             kb_we;
	logic [KB_AW-1:0] kb_waddr, kb_raddr;
	logic [7:0]       kb_wdata;
	logic [15:0]      kw_mem [2*KEY_WORDS];
	logic [15:0]      kw_rd_q;
	logic             kw_we;
	logic [KW_AW:0]   kw_waddr, kw_raddr;
	logic [15:0]      kw_wdata;

	logic             accept, out_free, blk_full;
	logic [63:0]      padded, r_next, plain;
	logic [7:0]       pad_val, ext_byte, dpad;
	logic [3:0]       rnd_d;
	logic [1:0]       w_d, rn_lane;
	logic             mash_d, step_last;
	logic [15:0]      rn_word;
	step_ctl_t        ctl;

	assign accept   = valid && ready;
	assign out_free = !out_valid_q || out_ready;
	assign blk_full = byte_count >= 4'd8;
	assign ext_byte = PI_TABLE[prev_q + kb_rd_q];
	assign plain    = r_q ^ dec_chain_q;
	assign dpad     = plain[63:56];

	// final block padding
	always_comb begin
		pad_val = 8'd8 - {4'd0, byte_count};
		padded  = block_data;
		if (last && !blk_full) begin
			for (int b = 0; b < 8; b++) begin
				if (4'(b) >= byte_count) padded[8*b +: 8] = pad_val;
			end
		end
	end

	// step datapath
	assign ctl = '{dec: dec_q, mash: mash_q, w: w_q};

	rc2c_step u_step (
		.r      (r_q),
		.ctl    (ctl),
		.k      (kw_rd_q),
		.r_next (r_next)
	);

	// step sequence: 16 rounds of 4 mix steps, mash after rounds 4 and 10; decrypt runs the reverse order
	always_comb begin
		rnd_d     = rnd_q;
		w_d       = w_q;
		mash_d    = mash_q;
		step_last = 1'b0;
		if (!dec_q) begin
			step_last = !mash_q && rnd_q == 4'd15 && w_q == 2'd3;
			w_d = w_q + 2'd1;
			if (w_q == 2'd3) begin
				if (!mash_q && (rnd_q == 4'd4 || rnd_q == 4'd10)) begin
					mash_d = 1'b1;
				end else begin
					mash_d = 1'b0;
					rnd_d  = rnd_q + 4'd1;
				end
			end
		end else begin
			step_last = !mash_q && rnd_q == 4'd0 && w_q == 2'd0;
			w_d = w_q - 2'd1;
			if (w_q == 2'd0) begin
				if (!mash_q && (rnd_q == 4'd5 || rnd_q == 4'd11)) begin
					mash_d = 1'b1;
				end else begin
					mash_d = 1'b0;
					rnd_d  = rnd_q - 4'd1;
				end
			end
		end
		rn_lane = w_d + 2'd3;
		rn_word = r_next[16*rn_lane +: 16];
	end

	// sequencer next state and memory ports
	always_comb begin
		state_d  = state_q;
		kb_we    = 1'b0;
		kb_waddr = cnt_q[KB_AW-1:0];
		kb_wdata = key_byte;
		kb_raddr = ext_i_q;
		kw_we    = 1'b0;
		kw_waddr = {kdec_q, pj_q};
		kw_wdata = {kb_rd_q, lo_q};
		kw_raddr = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (valid) begin
					if (!operation[1]) begin
						kb_we = !cnt_q[7];
						if (last) begin
							state_d = (cnt_q >= 8'(KEY_BYTES - 1)) ? ST_PACK_LO : ST_EXT_RD;
						end
					end else begin
						kw_raddr = (operation == OP_DEC_BLK) ? '1 : '0;
						state_d  = ST_RUN;
					end
				end
			end
			ST_EXT_RD: state_d = ST_EXT_WR;
			ST_EXT_WR: begin
				kb_we    = 1'b1;
				kb_waddr = ext_n_q;
				kb_wdata = ext_byte;
				state_d  = (ext_n_q == '1) ? ST_PACK_LO : ST_EXT_RD;
			end
			ST_PACK_LO: begin
				kb_raddr = {pj_q, 1'b0};
				state_d  = ST_PACK_HI;
			end
			ST_PACK_HI: begin
				kb_raddr = {pj_q, 1'b1};
				state_d  = ST_PACK_WR;
			end
			ST_PACK_WR: begin
				kw_we   = 1'b1;
				state_d = (pj_q == '1) ? ST_IDLE : ST_PACK_LO;
			end
			ST_RUN: begin
				kw_raddr = mash_d ? {dec_q, rn_word[KW_AW-1:0]} : {dec_q, rnd_d, w_d};
				if (step_last) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = pad_pend_q ? ST_RUN : ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign ready = state_q == ST_IDLE;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// memories
	always_ff @(posedge clk) begin
		if (kb_we) kb_mem[kb_waddr] <= kb_wdata;
		kb_rd_q <= kb_mem[kb_raddr];
	end

	always_ff @(posedge clk) begin
		if (kw_we) kw_mem[kw_waddr] <= kw_wdata;
		kw_rd_q <= kw_mem[kw_raddr];
	end

	// control state with reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			pad_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
			enc_chain_q <= CHAIN_RESET;
			dec_chain_q <= CHAIN_RESET;
		end else begin
			if (accept && !operation[1]) begin
				if (last) cnt_q <= '0;
				else if (!cnt_q[7]) cnt_q <= cnt_q + 8'd1;
			end
			if (accept && operation == OP_ENC_BLK) begin
				pad_pend_q <= last && blk_full;
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
				pad_pend_q  <= 1'b0;
				if (dec_q) dec_chain_q <= cin_q;
				else enc_chain_q <= r_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept && !operation[1] && last) begin
			kdec_q  <= operation[0];
			ext_i_q <= '0;
			ext_n_q <= cnt_q[KB_AW-1:0] + 1'b1;
			prev_q  <= key_byte;
			pj_q    <= '0;
		end
		if (state_q == ST_EXT_WR) begin
			prev_q  <= ext_byte;
			ext_i_q <= ext_i_q + 1'b1;
			ext_n_q <= ext_n_q + 1'b1;
		end
		if (state_q == ST_PACK_HI) begin
			lo_q <= (pj_q == '0) ? PI_TABLE[kb_rd_q] : kb_rd_q;
		end
		if (state_q == ST_PACK_WR) pj_q <= pj_q + 1'b1;

		if (accept && operation[1]) begin
			dec_q  <= operation[0];
			r_q    <= operation[0] ? block_data : (padded ^ enc_chain_q);
			cin_q  <= block_data;
			rnd_q  <= operation[0] ? 4'd15 : 4'd0;
			w_q    <= operation[0] ? 2'd3 : 2'd0;
			mash_q <= 1'b0;
			last_q <= last && (operation[0] || !blk_full);
		end
		if (state_q == ST_RUN) begin
			r_q    <= r_next;
			rnd_q  <= rnd_d;
			w_q    <= w_d;
			mash_q <= mash_d;
		end
		if (state_q == ST_DONE && out_free) begin
			out_last_q  <= last_q;
			pad_error_q <= 1'b0;
			out_bytes_q <= 4'd8;
			if (dec_q) begin
				out_block_q <= plain;
				if (last_q) begin
					if (dpad == 8'd0 || dpad > 8'd8) begin
						pad_error_q <= 1'b1;
						out_bytes_q <= 4'd0;
					end else begin
						out_bytes_q <= 4'd8 - dpad[3:0];
					end
				end
			end else begin
				out_block_q <= r_q;
			end
			// second block of eight pad bytes
			if (pad_pend_q) begin
				r_q    <= r_q ^ PAD_FULL;
				rnd_q  <= 4'd0;
				w_q    <= 2'd0;
				mash_q <= 1'b0;
				last_q <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_block = out_block_q;
	assign out_bytes = out_bytes_q;
	assign out_last  = out_last_q;
	assign pad_error = pad_error_q;

	// checks
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 8'(KEY_BYTES))
		else $error("key byte count beyond buffer");

	a_blk_start: assert property (@(posedge clk) disable iff (!arst_n)
		valid && ready && operation[1] |=> state_q == ST_RUN)
		else $error("block item did not start the cipher");

	a_mash_round: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN && mash_q |->
		(!dec_q && (rnd_q == 4'd4 || rnd_q == 4'd10)) ||
		(dec_q && (rnd_q == 4'd5 || rnd_q == 4'd11)))
		else $error("mash step in wrong round");

	a_pad_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pad_pend_q |-> !ready)
		else $error("ready while pad block pending");

endmodule

[tb/tb_rc2_cbc_cipher.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rc2_cbc_cipher
// Self-checking bench for the RC2 CBC cipher: key loads into both stores,
// padded encrypt messages and decrypt messages built from known plaintext,
// checked block by block against an in-bench cipher model.
// ----------------------------------------------------------------------------
import rc2c_pkg::*;

typedef struct {
	logic [63:0] blk;
	logic [3:0]  nbytes;
	logic        lst;
	logic        err;
} cipher_out_t;

// cipher model and queue of blocks still owed by the block
class rc2_cbc_predictor;
	logic [15:0] enc_keys [64];
	logic [15:0] dec_keys [64];
	logic [7:0]  key_buf [128];
	int          key_cnt;
	logic [63:0] enc_chain;
	logic [63:0] dec_chain;
	cipher_out_t owed_blocks [$];
	int          errors;

	function new();
		key_cnt = 0;
		enc_chain = CHAIN_RESET;
		dec_chain = CHAIN_RESET;
		errors = 0;
		foreach (enc_keys[i]) begin
			enc_keys[i] = '0;
			dec_keys[i] = '0;
		end
		foreach (key_buf[i]) key_buf[i] = '0;
	endfunction

	function logic [15:0] key_word(bit dec_store, int idx);
		return dec_store ? dec_keys[idx] : enc_keys[idx];
	endfunction

	function logic [15:0] rot_left(logic [15:0] v, int s);
		return (v << s) | (v >> (16 - s));
	endfunction

	function int lane_rot(int w);
		return (w == 0) ? 1 : (w == 1) ? 2 : (w == 2) ? 3 : 5;
	endfunction

	function logic [63:0] encipher(bit dec_store, logic [63:0] x);
		logic [15:0] r [4];
		for (int w = 0; w < 4; w++) r[w] = x[16*w +: 16];
		for (int i = 0; i < 16; i++) begin
			for (int w = 0; w < 4; w++) begin
				r[w] = r[w] + (r[(w+1)&3] & ~r[(w+3)&3]) + (r[(w+2)&3] & r[(w+3)&3])
					+ key_word(dec_store, 4*i + w);
				r[w] = rot_left(r[w], lane_rot(w));
			end
			if (i == 4 || i == 10)
				for (int w = 0; w < 4; w++)
					r[w] = r[w] + key_word(dec_store, r[(w+3)&3][5:0]);
		end
		return {r[3], r[2], r[1], r[0]};
	endfunction

	function logic [63:0] decipher(logic [63:0] x);
		logic [15:0] r [4];
		for (int w = 0; w < 4; w++) r[w] = x[16*w +: 16];
		for (int i = 15; i >= 0; i--) begin
			for (int w = 3; w >= 0; w--) begin
				r[w] = rot_left(r[w], 16 - lane_rot(w));
				r[w] = r[w] - ((r[(w+1)&3] & ~r[(w+3)&3]) + (r[(w+2)&3] & r[(w+3)&3])
					+ dec_keys[4*i + w]);
			end
			if (i == 5 || i == 11)
				for (int w = 3; w >= 0; w--)
					r[w] = r[w] - dec_keys[r[(w+3)&3][5:0]];
		end
		return {r[3], r[2], r[1], r[0]};
	endfunction

	// buffer fill through the permutation, then pack into key words
	function void expand_key(bit dec_store);
		int n;
		n = key_cnt;
		for (int i = 0; n < 128; i++, n++)
			key_buf[n] = PI_TABLE[8'(key_buf[n-1] + key_buf[i])];
		key_buf[0] = PI_TABLE[key_buf[0]];
		for (int i = 0; i < 64; i++)
			if (dec_store) dec_keys[i] = {key_buf[2*i+1], key_buf[2*i]};
			else enc_keys[i] = {key_buf[2*i+1], key_buf[2*i]};
	endfunction

	function void owe(logic [63:0] blk, logic [3:0] nb, logic lst, logic err);
		cipher_out_t o;
		o.blk = blk; o.nbytes = nb; o.lst = lst; o.err = err;
		owed_blocks.push_back(o);
	endfunction

	function void note_item(logic [1:0] op, logic [7:0] kb, logic [63:0] data,
			logic [3:0] cnt, logic lst);
		logic [63:0] plain;
		logic [7:0]  pad;
		if (op == OP_ENC_KEY || op == OP_DEC_KEY) begin
			if (key_cnt < 128) begin
				key_buf[key_cnt] = kb;
				key_cnt++;
			end
			if (lst) begin
				expand_key(op == OP_DEC_KEY);
				key_cnt = 0;
			end
		end else if (op == OP_ENC_BLK) begin
			if (lst && cnt < 8)
				for (int b = 0; b < 8; b++)
					if (b >= cnt) data[8*b +: 8] = 8'(8 - cnt);
			enc_chain = encipher(0, data ^ enc_chain);
			owe(enc_chain, 4'd8, lst && cnt < 8, 1'b0);
			if (lst && cnt >= 8) begin
				enc_chain = encipher(0, PAD_FULL ^ enc_chain);
				owe(enc_chain, 4'd8, 1'b1, 1'b0);
			end
		end else begin
			plain = decipher(data) ^ dec_chain;
			dec_chain = data;
			pad = plain[63:56];
			if (!lst) owe(plain, 4'd8, 1'b0, 1'b0);
			else if (pad == 0 || pad > 8) owe(plain, 4'd0, 1'b1, 1'b1);
			else owe(plain, 4'(8 - pad), 1'b1, 1'b0);
		end
	endfunction

	function void check_block(logic [63:0] blk, logic [3:0] nb, logic lst, logic err);
		cipher_out_t e;
		if (owed_blocks.size() == 0) begin
			$error("unexpected result block %h", blk);
			errors++;
			return;
		end
		e = owed_blocks.pop_front();
		if (blk !== e.blk) begin
			$error("out_block expected %h actual %h", e.blk, blk);
			errors++;
		end
		if (nb !== e.nbytes) begin
			$error("out_bytes expected %0d actual %0d", e.nbytes, nb);
			errors++;
		end
		if (lst !== e.lst) begin
			$error("out_last expected %0b actual %0b", e.lst, lst);
			errors++;
		end
		if (err !== e.err) begin
			$error("pad_error expected %0b actual %0b", e.err, err);
			errors++;
		end
	endfunction
endclass

module tb_rc2_cbc_cipher;
	localparam int ITEM_TARGET = 1900;
	localparam int QUIET_FROM  = 1650;
	localparam int DRAIN_CYCLES = 600;
	localparam int CYCLE_LIMIT = 3000000;

	logic        clk;
	logic        arst_n;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [7:0]  key_byte;
	logic [63:0] block_data;
	logic [3:0]  byte_count;
	logic        last;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] out_block;
	logic [3:0]  out_bytes;
	logic        out_last;
	logic        pad_error;

	rc2_cbc_predictor model;
	int  items_sent;
	bit  quiet;
	bit  long_hold;
	longint cycles;

	rc2_cbc_cipher DUT (
		.clk(clk), .arst_n(arst_n), .valid(valid), .ready(ready),
		.operation(operation), .key_byte(key_byte), .block_data(block_data),
		.byte_count(byte_count), .last(last), .out_valid(out_valid),
		.out_ready(out_ready), .out_block(out_block), .out_bytes(out_bytes),
		.out_last(out_last), .pad_error(pad_error)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("rc2_cbc_cipher verification failed");
			$finish;
		end
	end

	// result check
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			model.check_block(out_block, out_bytes, out_last, pad_error);
	end

	// receiver stalls: random bursts, plus one long hold on request
	initial begin
		int hold;
		hold = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_ready <= 1'b0;
				hold = 800;
				while (hold > 0) begin
					@(negedge clk);
					hold--;
				end
				long_hold = 0;
			end else if (hold > 0) begin
				hold--;
			end else if (!quiet && $urandom_range(0, 15) == 0) begin
				out_ready <= 1'b0;
				hold = $urandom_range(0, 14);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// one item: optional idle burst, drive at negedge, wait for the handshake
	task automatic send_item(logic [1:0] op, logic [7:0] kb, logic [63:0] data,
			logic [3:0] cnt, logic lst);
		int gap;
		gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 15) : 0;
		if (gap > 0) begin
			@(negedge clk);
			valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		valid <= 1'b1;
		operation <= op;
		key_byte <= kb;
		block_data <= data;
		byte_count <= cnt;
		last <= lst;
		do @(posedge clk); while (!ready);
		model.note_item(op, kb, data, cnt, lst);
		items_sent++;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// key of len bytes for one store; mixed picks either op for the early bytes
	task automatic load_key(bit dec_store, int len, bit mixed);
		logic [1:0] op;
		for (int i = 0; i < len; i++) begin
			op = dec_store ? OP_DEC_KEY : OP_ENC_KEY;
			if (mixed && i < len - 1) op = $urandom_range(0, 1) ? OP_DEC_KEY : OP_ENC_KEY;
			send_item(op, 8'($urandom), rand64(), 4'($urandom), i == len - 1);
		end
	endtask

	// ciphertext chosen so the block decrypts to plain
	task automatic send_dec_plain(logic [63:0] plain, logic lst);
		send_item(OP_DEC_BLK, 8'($urandom),
			model.encipher(1, plain ^ model.dec_chain), 4'($urandom), lst);
	endtask

	task automatic enc_message(int nblk, logic [3:0] final_cnt);
		for (int i = 0; i < nblk; i++)
			send_item(OP_ENC_BLK, 8'($urandom), rand64(),
				(i == nblk - 1) ? final_cnt : 4'($urandom), i == nblk - 1);
	endtask

	task automatic dec_message(int nblk, logic [7:0] pad);
		for (int i = 0; i < nblk - 1; i++) send_dec_plain(rand64(), 1'b0);
		send_dec_plain({pad, 56'(rand64())}, 1'b1);
	endtask

	// stop offering items, then wait for every owed result
	task automatic wait_drained();
		@(negedge clk);
		valid <= 1'b0;
		while (model.owed_blocks.size() != 0) @(posedge clk);
	endtask

	initial begin
		int  pick;
		bit  paused;
		model = new();
		cycles = 0;
		items_sent = 0;
		quiet = 0;
		long_hold = 0;
		paused = 0;
		valid = 1'b0;
		operation = OP_ENC_KEY;
		key_byte = '0;
		block_data = '0;
		byte_count = '0;
		last = 1'b0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: short keys with extreme bytes, then pad corners
		send_item(OP_ENC_KEY, 8'h00, '0, 4'd0, 1'b0);
		send_item(OP_ENC_KEY, 8'hFF, '1, 4'hF, 1'b1);
		send_item(OP_DEC_KEY, 8'hFF, '0, 4'd8, 1'b0);
		send_item(OP_DEC_KEY, 8'h00, '1, 4'd1, 1'b1);
		send_item(OP_ENC_BLK, 8'h00, '0, 4'd8, 1'b0);
		send_item(OP_ENC_BLK, 8'hFF, '1, 4'd0, 1'b1);
		send_item(OP_ENC_BLK, 8'h00, 64'h0123_4567_89AB_CDEF, 4'd3, 1'b1);
		send_item(OP_ENC_BLK, 8'h00, '1, 4'd7, 1'b1);
		send_item(OP_ENC_BLK, 8'h00, '0, 4'd8, 1'b1);
		send_item(OP_ENC_BLK, 8'h00, '1, 4'd15, 1'b1);
		send_item(OP_ENC_BLK, 8'h00, '1, 4'd1, 1'b1);
		send_dec_plain('0, 1'b0);
		send_dec_plain('1, 1'b0);
		send_dec_plain({8'h00, 56'h0}, 1'b1);
		send_dec_plain({8'h01, 56'hFF_FFFF_FFFF_FFFF}, 1'b1);
		send_dec_plain({8'h08, 56'h0}, 1'b1);
		send_dec_plain({8'h09, 56'h0}, 1'b1);
		send_dec_plain({8'hFF, 56'h0}, 1'b1);
		send_item(OP_DEC_BLK, 8'h00, '1, 4'd0, 1'b1);

		// random: messages (some decrypts with bad padding), key reloads and stray decrypt blocks
		long_hold = 1;
		while (items_sent < ITEM_TARGET) begin
			if (items_sent >= QUIET_FROM) quiet = 1;
			if (!paused && items_sent > 900) begin
				wait_drained();
				paused = 1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 8)
				load_key($urandom_range(0, 1), ($urandom_range(0, 9) == 0) ?
					$urandom_range(120, 140) : $urandom_range(1, 16), $urandom_range(0, 3) == 0);
			else if (pick < 50)
				enc_message($urandom_range(1, 4), 4'($urandom_range(0, 15)));
			else if (pick < 93)
				dec_message($urandom_range(1, 4), ($urandom_range(0, 4) == 0) ?
					8'($urandom) : 8'($urandom_range(1, 8)));
			else
				send_item(OP_DEC_BLK, 8'($urandom), rand64(), 4'($urandom), $urandom_range(0, 1));
		end
		@(negedge clk);
		valid <= 1'b0;

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (model.errors == 0 && model.owed_blocks.size() == 0) begin
			$display("rc2_cbc_cipher verification clean");
		end else begin
			$display("rc2_cbc_cipher verification failed");
		end
		$finish;
	end
endmodule
